FILE: rtl/memory_selftest_xorshift_pattern_top_macros.svh
// Assertion macros for the memory self-test RTL; only mstx_engine includes them.
// Depends on nothing; files that assert include it by name.
`ifndef MEMORY_SELFTEST_XORSHIFT_PATTERN_TOP_MACROS_SVH
`define MEMORY_SELFTEST_XORSHIFT_PATTERN_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSTX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSTX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mstx_pkg.sv
// Types, codes and the xorshift32 step for the memory self-test sequencer.
// Depends on nothing; used by mstx_engine and the top level.
package mstx_pkg;

	localparam logic [31:0] SEED            = 32'h1357_9BDF;
	localparam logic [23:0] COUNT_MAX       = 24'hFF_FFFF;
	localparam logic [31:0] DEF_WINDOW_BASE = 32'h4000_0000;
	localparam logic [31:0] DEF_WINDOW_END  = 32'h41FF_FFFF;

	// Reset values of the setup registers
	localparam logic [31:0] RST_TEST_ADDRESS = 32'd0;
	localparam logic [31:0] RST_TEST_SIZE    = 32'd0;
	localparam logic [31:0] RST_MAX_WORDS    = 32'd8192;

	// Setup register indexes
	localparam logic [1:0] CFG_TEST_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_TEST_SIZE    = 2'd1;
	localparam logic [1:0] CFG_MAX_WORDS    = 2'd2;

	// Input beat kinds
	localparam logic [1:0] ACT_START    = 2'd0;
	localparam logic [1:0] ACT_ADVANCE  = 2'd1;
	localparam logic [1:0] ACT_RESPONSE = 2'd2;

	// Memory commands
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Reported status
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RUNNING = 3'd1;
	localparam logic [2:0] ST_PASSED  = 3'd2;
	localparam logic [2:0] ST_FAILED  = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WRITE,
		PH_READ,
		PH_PASS,
		PH_FAIL,
		PH_INVALID
	} phase_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] mem_address;
		logic [31:0] mem_wdata;
		logic [2:0]  test_status;
		logic [31:0] fail_address;
		logic [31:0] fail_expected;
		logic [31:0] fail_actual;
	} mstx_res_t;

	function automatic logic [31:0] xorshift(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		a = v ^ (v << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

FILE: rtl/mstx_engine.sv
// Sequencer state and one-beat step logic of the memory self-test.
// Depends on mstx_pkg and the assertion macro header.
`include "memory_selftest_xorshift_pattern_top_macros.svh"

module mstx_engine #(
	parameter logic [31:0] WINDOW_BASE = mstx_pkg::DEF_WINDOW_BASE,
	parameter logic [31:0] WINDOW_END  = mstx_pkg::DEF_WINDOW_END
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [1:0]            action,
	input  logic [31:0]           mem_rdata,
	input  logic [31:0]           test_address,
	input  logic [31:0]           test_size,
	input  logic [31:0]           max_words,
	output mstx_pkg::mstx_res_t   res
);

	mstx_pkg::phase_t phase_q, phase_d;
	logic [31:0] pattern_q, pattern_d;
	logic [23:0] word_index_q, word_index_d;
	logic [23:0] word_count_q, word_count_d;
	logic [31:0] fail_addr_q, fail_addr_d;
	logic [31:0] fail_exp_q, fail_exp_d;
	logic [31:0] fail_act_q, fail_act_d;

	logic        cfg_ok;
	logic [32:0] room;
	logic [31:0] size_words;
	logic [31:0] lim;
	logic [23:0] count_new;
	logic [31:0] pat_next;
	logic [31:0] addr_cur;
	logic [23:0] index_inc;

	assign room       = {1'b0, WINDOW_END} - {1'b0, test_address} + 33'd1;
	assign cfg_ok     = (test_address >= WINDOW_BASE) && (test_address <= WINDOW_END)
	                 && (test_address[1:0] == 2'b00) && (test_size >= 32'd4)
	                 && (max_words != 32'd0) && ({1'b0, test_size} <= room);
	assign size_words = {2'b00, test_size[31:2]};
	assign lim        = (max_words < size_words) ? max_words : size_words;
	assign count_new  = (lim > {8'd0, mstx_pkg::COUNT_MAX}) ? mstx_pkg::COUNT_MAX : lim[23:0];
	assign pat_next   = mstx_pkg::xorshift(pattern_q);
	assign addr_cur   = test_address + {6'd0, word_index_q, 2'b00};
	assign index_inc  = word_index_q + 24'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= mstx_pkg::PH_IDLE;
			pattern_q    <= mstx_pkg::SEED;
			word_index_q <= '0;
			word_count_q <= '0;
			fail_addr_q  <= '0;
			fail_exp_q   <= '0;
			fail_act_q   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			pattern_q    <= pattern_d;
			word_index_q <= word_index_d;
			word_count_q <= word_count_d;
			fail_addr_q  <= fail_addr_d;
			fail_exp_q   <= fail_exp_d;
			fail_act_q   <= fail_act_d;
		end
	end

	always_comb begin
		phase_d         = phase_q;
		pattern_d       = pattern_q;
		word_index_d    = word_index_q;
		word_count_d    = word_count_q;
		fail_addr_d     = fail_addr_q;
		fail_exp_d      = fail_exp_q;
		fail_act_d      = fail_act_q;
		res.command     = mstx_pkg::CMD_NONE;
		res.mem_address = '0;
		res.mem_wdata   = '0;
		case (action)
			mstx_pkg::ACT_START: begin
				fail_addr_d  = '0;
				fail_exp_d   = '0;
				fail_act_d   = '0;
				pattern_d    = mstx_pkg::SEED;
				word_index_d = '0;
				if (!cfg_ok) begin
					phase_d      = mstx_pkg::PH_INVALID;
					word_count_d = '0;
				end else begin
					word_count_d    = count_new;
					phase_d         = mstx_pkg::PH_WRITE;
					res.command     = mstx_pkg::CMD_WRITE;
					res.mem_address = test_address;
					res.mem_wdata   = mstx_pkg::xorshift(mstx_pkg::SEED);
					pattern_d       = mstx_pkg::xorshift(mstx_pkg::SEED);
					word_index_d    = 24'd1;
				end
			end
			mstx_pkg::ACT_ADVANCE: begin
				if (phase_q == mstx_pkg::PH_WRITE) begin
					if (word_index_q < word_count_q) begin
						res.command     = mstx_pkg::CMD_WRITE;
						res.mem_address = addr_cur;
						res.mem_wdata   = pat_next;
						pattern_d       = pat_next;
						word_index_d    = index_inc;
					end else begin
						// Write pass done: reseed and open the read pass
						phase_d         = mstx_pkg::PH_READ;
						pattern_d       = mstx_pkg::SEED;
						word_index_d    = '0;
						res.command     = mstx_pkg::CMD_READ;
						res.mem_address = test_address;
					end
				end
			end
			mstx_pkg::ACT_RESPONSE: begin
				if (phase_q == mstx_pkg::PH_READ) begin
					pattern_d = pat_next;
					if (mem_rdata != pat_next) begin
						fail_addr_d = addr_cur;
						fail_exp_d  = pat_next;
						fail_act_d  = mem_rdata;
						phase_d     = mstx_pkg::PH_FAIL;
					end else begin
						word_index_d = index_inc;
						if (index_inc >= word_count_q) begin
							phase_d = mstx_pkg::PH_PASS;
						end else begin
							res.command     = mstx_pkg::CMD_READ;
							res.mem_address = test_address + {6'd0, index_inc, 2'b00};
						end
					end
				end
			end
			default: begin
			end
		endcase

		case (phase_d)
			mstx_pkg::PH_WRITE,
			mstx_pkg::PH_READ:    res.test_status = mstx_pkg::ST_RUNNING;
			mstx_pkg::PH_PASS:    res.test_status = mstx_pkg::ST_PASSED;
			mstx_pkg::PH_FAIL:    res.test_status = mstx_pkg::ST_FAILED;
			mstx_pkg::PH_INVALID: res.test_status = mstx_pkg::ST_INVALID;
			default:              res.test_status = mstx_pkg::ST_IDLE;
		endcase
		res.fail_address  = fail_addr_d;
		res.fail_expected = fail_exp_d;
		res.fail_actual   = fail_act_d;
	end

	`MSTX_ASSERT_NOW(a_read_index_in_range, clk, arst_n,
		phase_q == mstx_pkg::PH_READ, word_index_q < word_count_q,
		"read pass index reached the word count")
	`MSTX_ASSERT_NOW(a_record_only_on_fail, clk, arst_n,
		phase_q != mstx_pkg::PH_FAIL,
		(fail_addr_q == 32'd0) && (fail_exp_q == 32'd0) && (fail_act_q == 32'd0),
		"failure record set outside the fail phase")
	`MSTX_ASSERT_NEXT(a_start_seeds_pattern, clk, arst_n,
		step && (action == mstx_pkg::ACT_START) && (res.command == mstx_pkg::CMD_WRITE),
		pattern_q == mstx_pkg::xorshift(mstx_pkg::SEED),
		"start did not leave the first pattern word")
	`MSTX_ASSERT_NOW(a_command_while_running, clk, arst_n,
		step && (res.command != mstx_pkg::CMD_NONE),
		res.test_status == mstx_pkg::ST_RUNNING,
		"memory command issued outside a running test")

endmodule

FILE: rtl/memory_selftest_xorshift_pattern_top.sv
// Top level of the memory self-test sequencer: stream ports, setup registers,
// input and result registers. Depends on mstx_pkg and mstx_engine.
//
// Usage:
//   Setup: write test_address (index 0), test_size (index 1) and max_words
//   (index 2) on the cfg channel while the block is idle; cfg_ready is always high.
//   Input stream (s_axis): tuser carries the action (start, advance, read response),
//   tdata the word read back from memory. Every input beat yields exactly one
//   result beat on m_axis: tuser is the memory command (none, write, read), tdata
//   holds address, write data, status and the failure record.
//   Start checks the setup and issues the write of word 0; each advance issues the
//   next write, then the first read; each read response is compared with the
//   regenerated xorshift32 word and issues the next read until a mismatch or pass.
//   Path: input register, then the result register fed by the step logic.
//   Throughput: one beat per cycle while the receiver takes results, set by the
//   combinational xorshift step and compare in the engine.
//   Stall: when m_axis_tready is low the result is held; the input register takes
//   one more beat if it is empty, then s_axis_tready drops until the result moves on.
//   Reset: arst_n clears all valid flags and the test state to idle, and returns
//   the setup registers to their reset values (max_words 8192).

module memory_selftest_xorshift_pattern_top #(
	parameter logic [31:0] WINDOW_BASE = mstx_pkg::DEF_WINDOW_BASE,
	parameter logic [31:0] WINDOW_END  = mstx_pkg::DEF_WINDOW_END
) (
	input  logic         clk,
	input  logic         arst_n,
	// setup write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // [31:0] mem_rdata
	input  logic [1:0]   s_axis_tuser,   // [1:0] action
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] mem_address, [63:32] mem_wdata, [66:64] test_status,
	// [98:67] fail_address, [130:99] fail_expected, [162:131] fail_actual, rest zero
	output logic [167:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // [1:0] command
);

	logic [31:0] test_address_q;
	logic [31:0] test_size_q;
	logic [31:0] max_words_q;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [31:0] rdata_s1;

	logic         m_valid_q;
	logic [167:0] m_tdata_q;
	logic [1:0]   m_tuser_q;

	logic                out_free;
	logic                step;
	mstx_pkg::mstx_res_t res;

	assign cfg_ready = 1'b1;

	// Setup registers; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_address_q <= mstx_pkg::RST_TEST_ADDRESS;
			test_size_q    <= mstx_pkg::RST_TEST_SIZE;
			max_words_q    <= mstx_pkg::RST_MAX_WORDS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mstx_pkg::CFG_TEST_ADDRESS: test_address_q <= cfg_data;
				mstx_pkg::CFG_TEST_SIZE:    test_size_q    <= cfg_data;
				mstx_pkg::CFG_MAX_WORDS:    max_words_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the held beat whenever the result register is free or draining
	assign out_free      = !m_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			rdata_s1  <= s_axis_tdata;
		end
	end

	mstx_engine #(
		.WINDOW_BASE (WINDOW_BASE),
		.WINDOW_END  (WINDOW_END)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.action       (action_s1),
		.mem_rdata    (rdata_s1),
		.test_address (test_address_q),
		.test_size    (test_size_q),
		.max_words    (max_words_q),
		.res          (res)
	);

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tuser_q <= res.command;
			m_tdata_q <= {5'd0, res.fail_actual, res.fail_expected, res.fail_address,
			              res.test_status, res.mem_wdata, res.mem_address};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for memory_selftest_xorshift_pattern_top: directed table, then
// random test runs checked beat by beat against an in-bench model of the sequencer.
// Depends on mstx_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
	import mstx_pkg::*;

	localparam int          RESET_CYCLES   = 10;
	localparam int          LATENCY        = 2;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          HOLD_CYCLES    = 120;
	localparam int          ITEM_TARGET    = 1100;
	localparam int          PROFILE_SPAN   = 367;
	localparam logic [1:0]  ACT_UNUSED     = 2'd3;
	localparam logic [31:0] WINDOW_BYTES   = DEF_WINDOW_END - DEF_WINDOW_BASE + 32'd1;

	// Kinds of rows in the directed table and how a row builds its read data
	typedef enum logic {ROW_BEAT, ROW_SETUP} row_kind_t;
	typedef enum logic [1:0] {RD_FIXED, RD_MATCH, RD_FLIP} rd_mode_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  code;    // action for a beat, register index for a setup write
		logic [31:0] value;   // read data, flip mask or register value
		rd_mode_t    mode;
		logic        typed;   // expected beat written out below: no command, zero record
		logic [2:0]  status;
	} plan_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = 2'd0;
	logic [31:0]  cfg_data = 32'd0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = 32'd0;   // [31:0] mem_rdata
	logic [1:0]   s_axis_tuser = 2'd0;    // [1:0] action
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// [31:0] mem_address, [63:32] mem_wdata, [66:64] test_status,
	// [98:67] fail_address, [130:99] fail_expected, [162:131] fail_actual
	logic [167:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;           // [1:0] command

	// Model copy of the setup registers and of the sequencer state
	logic [31:0] setup_addr_q  = RST_TEST_ADDRESS;
	logic [31:0] setup_size_q  = RST_TEST_SIZE;
	logic [31:0] setup_limit_q = RST_MAX_WORDS;
	phase_t      phase_q       = PH_IDLE;
	logic [31:0] pattern_q     = SEED;
	logic [23:0] word_idx_q    = 24'd0;
	logic [23:0] word_total_q  = 24'd0;
	logic [31:0] fail_addr_q   = 32'd0;
	logic [31:0] fail_exp_q    = 32'd0;
	logic [31:0] fail_act_q    = 32'd0;

	mstx_res_t pending_results[$];

	int   mismatches    = 0;
	int   useful_beats  = 0;
	int   profile       = 0;
	int   send_gap_pct  = 26;
	int   recv_gap_pct  = 68;
	int   quiet_cycles  = 0;
	logic hold_pending  = 1'b0;

	// Directed table: reset behavior, ignored actions in each phase but pass, each way
	// a setup can be rejected, a one-word pass, a restart, and mismatches at words 0 and 1.
	plan_row_t plan [0:35] = '{
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b1, ST_IDLE},
		'{ROW_BEAT,  ACT_RESPONSE,     32'hFFFF_FFFF,          RD_FIXED, 1'b1, ST_IDLE},
		'{ROW_BEAT,  ACT_UNUSED,       32'hFFFF_FFFF,          RD_FIXED, 1'b1, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_TEST_ADDRESS, DEF_WINDOW_END - 32'd3, RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_SETUP, CFG_TEST_SIZE,    32'd4,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_RESPONSE,     32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_ADVANCE,      32'hFFFF_FFFF,          RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_RESPONSE,     32'd0,                  RD_MATCH, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_RESPONSE,     32'h8000_0001,          RD_FLIP,  1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_SETUP, CFG_TEST_SIZE,    32'd8,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_TEST_ADDRESS, 32'hFFFF_FFFC,          RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_TEST_ADDRESS, DEF_WINDOW_BASE + 32'd2, RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_TEST_ADDRESS, DEF_WINDOW_BASE - 32'd4, RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_TEST_ADDRESS, DEF_WINDOW_BASE,        RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_SETUP, CFG_TEST_SIZE,    32'd3,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_TEST_SIZE,    WINDOW_BYTES,           RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_SETUP, CFG_MAX_WORDS,    32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b1, ST_INVALID},
		'{ROW_SETUP, CFG_MAX_WORDS,    32'd2,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_START,        32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_ADVANCE,      32'd0,                  RD_FIXED, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_RESPONSE,     32'd0,                  RD_MATCH, 1'b0, ST_IDLE},
		'{ROW_BEAT,  ACT_RESPONSE,     32'hFFFF_FFFF,          RD_FLIP,  1'b0, ST_IDLE}
	};

	memory_selftest_xorshift_pattern_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One xorshift32 step: shift left 13, right 17, left 5, xor each time
	function automatic logic [31:0] next_word(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ {v[18:0], 13'd0};
		t = t ^ {17'd0, t[31:17]};
		return t ^ {t[26:0], 5'd0};
	endfunction

	// Byte address of word idx, wrapping at 2^32
	function automatic logic [31:0] word_address(input logic [23:0] idx);
		return setup_addr_q + {6'd0, idx, 2'b00};
	endfunction

	// Advance the sequencer model by one input beat and return the result beat it gives
	function automatic mstx_res_t predict_step(input logic [1:0] act, input logic [31:0] rdata);
		mstx_res_t   r;
		logic [63:0] room;
		logic [31:0] n;
		logic [31:0] word;
		logic        valid;
		r = '0;
		r.command = CMD_NONE;
		if (act == ACT_START) begin
			fail_addr_q = 32'd0;
			fail_exp_q  = 32'd0;
			fail_act_q  = 32'd0;
			pattern_q   = SEED;
			word_idx_q  = 24'd0;
			// room is computed in 64 bits so a size past the window end cannot wrap
			room  = {32'd0, DEF_WINDOW_END} - {32'd0, setup_addr_q} + 64'd1;
			valid = setup_addr_q >= DEF_WINDOW_BASE && setup_addr_q <= DEF_WINDOW_END &&
				setup_addr_q[1:0] == 2'b00 && setup_size_q >= 32'd4 &&
				setup_limit_q != 32'd0 && {32'd0, setup_size_q} <= room;
			if (!valid) begin
				phase_q      = PH_INVALID;
				word_total_q = 24'd0;
			end else begin
				n = setup_size_q >> 2;
				if (n > setup_limit_q)
					n = setup_limit_q;
				if (n > {8'd0, COUNT_MAX})
					n = {8'd0, COUNT_MAX};
				word_total_q  = n[23:0];
				phase_q       = PH_WRITE;
				pattern_q     = next_word(pattern_q);
				r.command     = CMD_WRITE;
				r.mem_address = word_address(24'd0);
				r.mem_wdata   = pattern_q;
				word_idx_q    = 24'd1;
			end
		end else if (act == ACT_ADVANCE && phase_q == PH_WRITE) begin
			if (word_idx_q < word_total_q) begin
				pattern_q     = next_word(pattern_q);
				r.command     = CMD_WRITE;
				r.mem_address = word_address(word_idx_q);
				r.mem_wdata   = pattern_q;
				word_idx_q    = word_idx_q + 24'd1;
			end else begin
				// write pass done: reseed and ask for word 0
				phase_q       = PH_READ;
				pattern_q     = SEED;
				word_idx_q    = 24'd0;
				r.command     = CMD_READ;
				r.mem_address = word_address(24'd0);
			end
		end else if (act == ACT_RESPONSE && phase_q == PH_READ) begin
			word      = next_word(pattern_q);
			pattern_q = word;
			if (rdata != word) begin
				fail_addr_q = word_address(word_idx_q);
				fail_exp_q  = word;
				fail_act_q  = rdata;
				phase_q     = PH_FAIL;
			end else begin
				word_idx_q = word_idx_q + 24'd1;
				if (word_idx_q >= word_total_q) begin
					phase_q = PH_PASS;
				end else begin
					r.command     = CMD_READ;
					r.mem_address = word_address(word_idx_q);
				end
			end
		end
		case (phase_q)
			PH_WRITE, PH_READ: r.test_status = ST_RUNNING;
			PH_PASS:           r.test_status = ST_PASSED;
			PH_FAIL:           r.test_status = ST_FAILED;
			PH_INVALID:        r.test_status = ST_INVALID;
			default:           r.test_status = ST_IDLE;
		endcase
		r.fail_address  = fail_addr_q;
		r.fail_expected = fail_exp_q;
		r.fail_actual   = fail_act_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one input beat after a random gap, hold it until accepted, then log what
	// the sequencer must answer. tvalid stays high on return so back-to-back beats
	// need no second assignment in the same step.
	task automatic send_item(input logic [1:0] act, input logic [31:0] rd, input logic typed,
		input logic [2:0] typed_status);
		mstx_res_t res;
		phase_t    prior;
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= rd;
		do @(posedge clk); while (!s_axis_tready);
		prior = phase_q;
		res   = predict_step(act, rd);
		if (typed) begin
			res = '{command: CMD_NONE, mem_address: 32'd0, mem_wdata: 32'd0,
				test_status: typed_status, fail_address: 32'd0, fail_expected: 32'd0,
				fail_actual: 32'd0};
		end
		pending_results.push_back(res);
		// beats the block merely ignores do not count toward the run length
		if (act == ACT_START || res.command != CMD_NONE || phase_q != prior)
			useful_beats++;
		// swap the idle profile, then drop idling and stall the receiver once at the
		// start of a run long enough to keep the sender busy through the hold
		if (profile == 0 && useful_beats >= PROFILE_SPAN) begin
			profile      = 1;
			send_gap_pct = 68;
			recv_gap_pct = 26;
		end else if (profile == 1 && useful_beats >= 2 * PROFILE_SPAN) begin
			profile      = 2;
			send_gap_pct = 0;
			recv_gap_pct = 0;
		end else if (profile == 2 && act == ACT_START && phase_q == PH_WRITE &&
			word_total_q >= 24'd4) begin
			profile      = 3;
			hold_pending = 1'b1;
		end
	endtask

	// Write one setup register with the block idle: drop tvalid, drain all results,
	// let the pipeline settle, then do the write beat.
	task automatic write_setup(input logic [1:0] idx, input logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 1) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TEST_ADDRESS: setup_addr_q  = val;
			CFG_TEST_SIZE:    setup_size_q  = val;
			CFG_MAX_WORDS:    setup_limit_q = val;
			default: ;
		endcase
	endtask

	// Receiver: random tready, plus one long hold-off counted here while the sender
	// keeps offering beats, so the block backs up and drops s_axis_tready
	initial begin : ready_driver
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Compare every result beat with the oldest logged expectation. Signals are read
	// at the edge before any nonblocking update, i.e. the values that made the beat.
	always @(posedge clk) begin : result_monitor
		mstx_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: tuser %h tdata %h",
					m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("command",       {30'd0, want.command}, {30'd0, m_axis_tuser});
				check_field("mem_address",   want.mem_address,      m_axis_tdata[31:0]);
				check_field("mem_wdata",     want.mem_wdata,        m_axis_tdata[63:32]);
				check_field("test_status",   {29'd0, want.test_status},
					{29'd0, m_axis_tdata[66:64]});
				check_field("fail_address",  want.fail_address,     m_axis_tdata[98:67]);
				check_field("fail_expected", want.fail_expected,    m_axis_tdata[130:99]);
				check_field("fail_actual",   want.fail_actual,      m_axis_tdata[162:131]);
			end
		end
	end

	// Watchdog: end the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int          shape;
		int          n;
		logic [31:0] addr;
		logic [31:0] size;
		logic [31:0] limit;
		logic [31:0] top;
		logic [31:0] slots;
		logic [31:0] rd;
		logic [31:0] flip;

		// Hold reset, then release it on a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP) begin
				write_setup(plan[i].code, plan[i].value);
			end else begin
				case (plan[i].mode)
					RD_MATCH: rd = next_word(pattern_q);
					RD_FLIP:  rd = next_word(pattern_q) ^ plan[i].value;
					default:  rd = plan[i].value;
				endcase
				send_item(plan[i].code, rd, plan[i].typed, plan[i].status);
			end
		end

		// Random test runs: mostly well-formed write and read passes of 1 to 12 words,
		// with a few rejected setups, stray actions and corrupted read data
		while (useful_beats < ITEM_TARGET) begin
			n     = $urandom_range(1, 12);
			shape = $urandom_range(0, 9);
			if (shape % 2 == 1) begin
				// size sets the word count, limit is loose or at its top
				size  = 4 * n + $urandom_range(0, 3);
				limit = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
					n + $urandom_range(0, 1000);
			end else begin
				// any size up to the whole window, limit sets the word count
				size  = $urandom_range(4 * n, WINDOW_BYTES);
				limit = n;
			end
			top   = DEF_WINDOW_END + 32'd1 - size;
			slots = (top - DEF_WINDOW_BASE) >> 2;
			case ($urandom_range(0, 3))
				0:       addr = DEF_WINDOW_BASE;
				1:       addr = DEF_WINDOW_BASE + (slots << 2);
				default: addr = DEF_WINDOW_BASE + ($urandom_range(0, slots) << 2);
			endcase
			if (shape == 0) begin
				// break the setup in one way
				case ($urandom_range(0, 4))
					0: addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
					1: addr[1:0] = 2'($urandom_range(1, 3));
					2: size = $urandom_range(0, 3);
					3: size = $urandom_range(0, 1) ? 32'hFFFF_FFFF :
						DEF_WINDOW_END + 32'd1 - addr + $urandom_range(1, 64);
					default: limit = 32'd0;
				endcase
			end
			write_setup(CFG_TEST_ADDRESS, addr);
			write_setup(CFG_TEST_SIZE, size);
			write_setup(CFG_MAX_WORDS, limit);

			send_item(ACT_START, $urandom, 1'b0, ST_IDLE);
			while (phase_q == PH_WRITE || phase_q == PH_READ) begin
				if ($urandom_range(99) < 6) begin
					// stray beat: any action, any data, a restart included
					send_item(2'($urandom_range(0, 3)), $urandom, 1'b0, ST_IDLE);
				end else if (phase_q == PH_WRITE) begin
					send_item(ACT_ADVANCE, $urandom, 1'b0, ST_IDLE);
				end else begin
					rd = next_word(pattern_q);
					if ($urandom_range(99) < 4) begin
						flip = $urandom;
						if (flip == 32'd0)
							flip = 32'd1 << $urandom_range(0, 31);
						rd = rd ^ flip;
					end
					send_item(ACT_RESPONSE, rd, 1'b0, ST_IDLE);
				end
			end
			if ($urandom_range(0, 2) == 0)
				send_item(2'($urandom_range(0, 3)), $urandom, 1'b0, ST_IDLE);
		end

		// Drain: drop tvalid, wait for every result, then let the pipeline settle
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
